>>> hdl/modbus_response_checker_top_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the Modbus response checker
// Concurrent assertion wrappers sampled on the rising clock edge and
// disabled while the synchronous active-low reset is held.
// ----------------------------------------------------------------------------
`ifndef MODBUS_RESPONSE_CHECKER_TOP_ASSERT_SVH
`define MODBUS_RESPONSE_CHECKER_TOP_ASSERT_SVH

// Antecedent and consequent in the same cycle.
`define MRC_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define MRC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hdl/mrc_pkg.sv
// ----------------------------------------------------------------------------
// Modbus response checker package
// Constants, result codes, shared types and the byte-wide CRC-16 update.
// ----------------------------------------------------------------------------
package mrc_pkg;

    localparam int MAX_FRAME = 256;
    // Byte count saturates at MAX_FRAME + 1, so it needs room for that value.
    localparam int LEN_W     = $clog2(MAX_FRAME + 2);

    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'hA001;

    // Result status codes.
    localparam logic [2:0] ST_READ  = 3'd0;
    localparam logic [2:0] ST_WRITE = 3'd1;
    localparam logic [2:0] ST_EXC   = 3'd2;
    localparam logic [2:0] ST_CRC   = 3'd3;
    localparam logic [2:0] ST_BAD   = 3'd4;
    localparam logic [2:0] ST_SHORT = 3'd5;

    // Function codes.
    localparam logic [7:0] FC_READ      = 8'h03;
    localparam logic [7:0] FC_WRITE     = 8'h06;
    localparam logic [7:0] FC_READ_EXC  = 8'h83;
    localparam logic [7:0] FC_WRITE_EXC = 8'h86;
    localparam logic [7:0] READ_COUNT   = 8'h02;

    // Byte positions within the frame.
    localparam logic [LEN_W-1:0] POS_FUNC  = LEN_W'(1);
    localparam logic [LEN_W-1:0] POS_TWO   = LEN_W'(2);
    localparam logic [LEN_W-1:0] POS_THREE = LEN_W'(3);
    localparam logic [LEN_W-1:0] POS_FOUR  = LEN_W'(4);
    localparam logic [LEN_W-1:0] POS_FIVE  = LEN_W'(5);

    // Minimum frame lengths.
    localparam logic [LEN_W-1:0] LEN_MIN   = LEN_W'(4);
    localparam logic [LEN_W-1:0] LEN_EXC   = LEN_W'(5);
    localparam logic [LEN_W-1:0] LEN_READ  = LEN_W'(7);
    localparam logic [LEN_W-1:0] LEN_WRITE = LEN_W'(8);
    localparam logic [LEN_W-1:0] LEN_MAX   = LEN_W'(MAX_FRAME);

    typedef struct packed {
        logic [LEN_W-1:0] len;
        logic             crc_ok;
        logic [7:0]       func;
        logic [7:0]       b2;
        logic [7:0]       b3;
        logic [7:0]       b4;
        logic [7:0]       b5;
    } t_frame_info;

    typedef struct packed {
        logic [2:0]  status;
        logic [7:0]  func_code;
        logic [7:0]  exc_code;
        logic [15:0] reg_value;
    } t_result;

    function automatic logic [15:0] crc_feed(input logic [15:0] crc_in,
                                             input logic [7:0]  data);
        logic [15:0] crc;
        crc = crc_in ^ {8'h00, data};
        for (int k = 0; k < 8; k++) begin
            if (crc[0]) begin
                crc = (crc >> 1) ^ CRC_POLY;
            end else begin
                crc = crc >> 1;
            end
        end
        return crc;
    endfunction

endpackage

>>> hdl/mrc_classify.sv
// ----------------------------------------------------------------------------
// Modbus response classifier
// Turns the length, CRC residue check and captured bytes of a finished
// frame into one result.
// ----------------------------------------------------------------------------
module mrc_classify (
    input  mrc_pkg::t_frame_info i_info,
    output mrc_pkg::t_result     o_result
);

    always_comb begin
        o_result           = '0;
        o_result.func_code = i_info.func;
        if (i_info.len < mrc_pkg::LEN_MIN) begin
            o_result.status = mrc_pkg::ST_SHORT;
        end else if (i_info.len > mrc_pkg::LEN_MAX) begin
            o_result.status = mrc_pkg::ST_BAD;
        end else if (!i_info.crc_ok) begin
            o_result.status = mrc_pkg::ST_CRC;
        end else if (i_info.func == mrc_pkg::FC_READ) begin
            if (i_info.b2 != mrc_pkg::READ_COUNT) begin
                o_result.status = mrc_pkg::ST_BAD;
            end else if (i_info.len < mrc_pkg::LEN_READ) begin
                o_result.status = mrc_pkg::ST_SHORT;
            end else begin
                o_result.status    = mrc_pkg::ST_READ;
                o_result.reg_value = {i_info.b3, i_info.b4};
            end
        end else if (i_info.func == mrc_pkg::FC_WRITE) begin
            if (i_info.len < mrc_pkg::LEN_WRITE) begin
                o_result.status = mrc_pkg::ST_SHORT;
            end else begin
                o_result.status    = mrc_pkg::ST_WRITE;
                o_result.reg_value = {i_info.b4, i_info.b5};
            end
        end else if (i_info.func inside {mrc_pkg::FC_READ_EXC, mrc_pkg::FC_WRITE_EXC}) begin
            if (i_info.len < mrc_pkg::LEN_EXC) begin
                o_result.status = mrc_pkg::ST_SHORT;
            end else begin
                o_result.status   = mrc_pkg::ST_EXC;
                o_result.exc_code = i_info.b2;
            end
        end else begin
            o_result.status = mrc_pkg::ST_BAD;
        end
    end

endmodule

>>> hdl/modbus_response_checker_top.sv
// A result appears once the last byte of a frame has passed the input register
// and then been registered in the result register.
// Throughput: one byte per cycle while no result is stalled, set by the byte-wide CRC
// update between the input register and the frame state; a stalled result holds one byte.
// Reset: synchronous, active low; clears both valid flags and returns the
// CRC to 0xFFFF and the byte count and captured bytes to zero.
// ----------------------------------------------------------------------------
// Modbus RTU response checker
// Runs CRC-16 over a received response frame, captures the header bytes and
// classifies the frame when its last byte arrives.
// ----------------------------------------------------------------------------
module modbus_response_checker_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [7:0]  i_rx_byte,
    input  logic        i_frame_end,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [2:0]  o_status,
    output logic [7:0]  o_func_code,
    output logic [7:0]  o_exc_code,
    output logic [15:0] o_reg_value
);

    logic                      r_in_valid;
    logic [7:0]                r_in_byte;
    logic                      r_in_end;

    logic [15:0]               r_crc,   n_crc;
    logic [mrc_pkg::LEN_W-1:0] r_index, n_index;
    logic [7:0]                r_func,  n_func;
    logic [7:0]                r_b2,    n_b2;
    logic [7:0]                r_b3,    n_b3;
    logic [7:0]                r_b4,    n_b4;
    logic [7:0]                r_b5,    n_b5;

    logic                      r_out_valid;
    mrc_pkg::t_result          r_result;

    logic                      w_fire;
    mrc_pkg::t_frame_info      w_info;
    mrc_pkg::t_result          w_result;

    // The held byte moves on whenever the result register can take a result.
    assign w_fire     = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || w_fire;

    always_comb begin
        n_crc  = mrc_pkg::crc_feed(r_crc, r_in_byte);
        n_func = (r_index == mrc_pkg::POS_FUNC)  ? r_in_byte : r_func;
        n_b2   = (r_index == mrc_pkg::POS_TWO)   ? r_in_byte : r_b2;
        n_b3   = (r_index == mrc_pkg::POS_THREE) ? r_in_byte : r_b3;
        n_b4   = (r_index == mrc_pkg::POS_FOUR)  ? r_in_byte : r_b4;
        n_b5   = (r_index == mrc_pkg::POS_FIVE)  ? r_in_byte : r_b5;
        // The count stops one past the longest legal frame.
        n_index = (r_index <= mrc_pkg::LEN_MAX) ? r_index + 1'b1 : r_index;
    end

    assign w_info = '{len:    n_index,
                      crc_ok: (n_crc == 16'h0000),
                      func:   n_func,
                      b2:     n_b2,
                      b3:     n_b3,
                      b4:     n_b4,
                      b5:     n_b5};

    mrc_classify u_classify (
        .i_info   (w_info),
        .o_result (w_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
        if (i_in_valid && o_in_ready) begin
            r_in_byte <= i_rx_byte;
            r_in_end  <= i_frame_end;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (w_fire && r_in_end)) begin
            r_crc   <= mrc_pkg::CRC_INIT;
            r_index <= '0;
            r_func  <= '0;
            r_b2    <= '0;
            r_b3    <= '0;
            r_b4    <= '0;
            r_b5    <= '0;
        end else if (w_fire) begin
            r_crc   <= n_crc;
            r_index <= n_index;
            r_func  <= n_func;
            r_b2    <= n_b2;
            r_b3    <= n_b3;
            r_b4    <= n_b4;
            r_b5    <= n_b5;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_fire && r_in_end) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
        if (w_fire && r_in_end) begin
            r_result <= w_result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_status    = r_result.status;
    assign o_func_code = r_result.func_code;
    assign o_exc_code  = r_result.exc_code;
    assign o_reg_value = r_result.reg_value;

endmodule

>>> hdl/mrc_assert_chk.sv
// ----------------------------------------------------------------------------
// Modbus response checker port assertions
// Watches the top-level ports for result consistency and stall behaviour.
// ----------------------------------------------------------------------------
`include "modbus_response_checker_top_assert.svh"

module mrc_assert_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        o_in_ready,
    input logic [7:0]  i_rx_byte,
    input logic        i_frame_end,
    input logic        o_out_valid,
    input logic        i_out_ready,
    input logic [2:0]  o_status,
    input logic [7:0]  o_func_code,
    input logic [7:0]  o_exc_code,
    input logic [15:0] o_reg_value
);

    `MRC_ASSERT_SAME(a_status_range, i_clk, i_rst_n,
                     o_out_valid, o_status <= mrc_pkg::ST_SHORT,
                     "status code out of range")

    `MRC_ASSERT_SAME(a_exc_only_on_exc, i_clk, i_rst_n,
                     o_out_valid && (o_status != mrc_pkg::ST_EXC),
                     o_exc_code == 8'h00,
                     "exception code set on a non-exception result")

    `MRC_ASSERT_SAME(a_value_only_on_rw, i_clk, i_rst_n,
                     o_out_valid && (o_status != mrc_pkg::ST_READ)
                         && (o_status != mrc_pkg::ST_WRITE),
                     o_reg_value == 16'h0000,
                     "register value set on a result without one")

    `MRC_ASSERT_NEXT(a_result_held, i_clk, i_rst_n,
                     o_out_valid && !i_out_ready,
                     o_out_valid && $stable(o_status) && $stable(o_func_code)
                         && $stable(o_exc_code) && $stable(o_reg_value),
                     "stalled result changed")

    // A byte that is refused stays on offer, unchanged, until it is taken.
    `MRC_ASSERT_NEXT(a_input_held, i_clk, i_rst_n,
                     i_in_valid && !o_in_ready,
                     i_in_valid && $stable(i_rx_byte) && $stable(i_frame_end),
                     "refused input byte changed")

endmodule

bind modbus_response_checker_top mrc_assert_chk u_mrc_assert_chk (.*);

>>> dv/modbus_response_checker_monitor.sv
// ----------------------------------------------------------------------------
// Modbus response checker monitor
// Watches both channels of the response checker. It keeps its own copy of
// the frame state, works out the classification due at each frame end, and
// compares every result transfer with the oldest outstanding prediction.
// ----------------------------------------------------------------------------
package mrc_tb_pkg;

    // Bit-serial form of the reflected CRC-16 update, least significant bit
    // of the data first.
    function automatic logic [15:0] crc16_update(input logic [15:0] crc,
                                                 input logic [7:0]  data);
        logic [15:0] acc;
        logic        fb;
        acc = crc;
        for (int i = 0; i < 8; i++) begin
            fb  = acc[0] ^ data[i];
            acc = acc >> 1;
            if (fb) begin
                acc = acc ^ mrc_pkg::CRC_POLY;
            end
        end
        return acc;
    endfunction

endpackage

module modbus_response_checker_monitor (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_in_ready,
    input  logic [7:0]  i_rx_byte,
    input  logic        i_frame_end,
    input  logic        i_out_valid,
    input  logic        i_out_ready,
    input  logic [2:0]  i_status,
    input  logic [7:0]  i_func_code,
    input  logic [7:0]  i_exc_code,
    input  logic [15:0] i_reg_value,
    output int          o_error_count,
    output int          o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    import mrc_pkg::*;
    import mrc_tb_pkg::*;

    logic [15:0]      crc_acc;
    logic [LEN_W-1:0] byte_count;
    logic [7:0]       func_q;
    logic [7:0]       count_q;
    logic [7:0]       byte3_q;
    logic [7:0]       byte4_q;
    logic [7:0]       byte5_q;

    t_result pending_results[$];
    int      mismatches = 0;
    int      pending_count = 0;

    assign o_error_count = mismatches;
    assign o_pending     = pending_count;

    task automatic clear_frame();
        crc_acc    = CRC_INIT;
        byte_count = '0;
        func_q     = '0;
        count_q    = '0;
        byte3_q    = '0;
        byte4_q    = '0;
        byte5_q    = '0;
    endtask

    // Folds one byte into the frame state and, on the last byte, queues the
    // classification of the whole frame.
    task automatic absorb_byte(input logic [7:0] data, input logic last);
        t_result res;
        case (byte_count)
            POS_FUNC:  func_q  = data;
            POS_TWO:   count_q = data;
            POS_THREE: byte3_q = data;
            POS_FOUR:  byte4_q = data;
            POS_FIVE:  byte5_q = data;
            default: ;
        endcase
        crc_acc = crc16_update(crc_acc, data);
        // The count stops one past the largest legal frame.
        if (byte_count <= LEN_MAX) begin
            byte_count = byte_count + 1'b1;
        end
        if (last) begin
            res           = '0;
            res.func_code = func_q;
            if (byte_count < LEN_MIN) begin
                res.status = ST_SHORT;
            end else if (byte_count > LEN_MAX) begin
                res.status = ST_BAD;
            end else if (crc_acc != 16'h0000) begin
                res.status = ST_CRC;
            end else if (func_q == FC_READ) begin
                if (count_q != READ_COUNT) begin
                    res.status = ST_BAD;
                end else if (byte_count < LEN_READ) begin
                    res.status = ST_SHORT;
                end else begin
                    res.status    = ST_READ;
                    res.reg_value = {byte3_q, byte4_q};
                end
            end else if (func_q == FC_WRITE) begin
                if (byte_count < LEN_WRITE) begin
                    res.status = ST_SHORT;
                end else begin
                    res.status    = ST_WRITE;
                    res.reg_value = {byte4_q, byte5_q};
                end
            end else if (func_q == FC_READ_EXC || func_q == FC_WRITE_EXC) begin
                if (byte_count < LEN_EXC) begin
                    res.status = ST_SHORT;
                end else begin
                    res.status   = ST_EXC;
                    res.exc_code = count_q;
                end
            end else begin
                res.status = ST_BAD;
            end
            pending_results.push_back(res);
            clear_frame();
        end
    endtask

    task automatic compare_field(input string name, input logic [15:0] want,
                                 input logic [15:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch: expected %0h, actual %0h",
                     $time, name, want, got);
            mismatches++;
        end
    endtask

    task automatic check_result();
        t_result want;
        if (pending_results.size() == 0) begin
            $display("%0t: unexpected result: expected none, actual status %0d func %0h",
                     $time, i_status, i_func_code);
            mismatches++;
        end else begin
            want = pending_results.pop_front();
            compare_field("status", 16'(want.status), 16'(i_status));
            compare_field("func_code", 16'(want.func_code), 16'(i_func_code));
            compare_field("exc_code", 16'(want.exc_code), 16'(i_exc_code));
            compare_field("reg_value", want.reg_value, i_reg_value);
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            clear_frame();
            pending_results.delete();
        end else begin
            if (i_out_valid && i_out_ready) begin
                check_result();
            end
            if (i_in_valid && i_in_ready) begin
                absorb_byte(i_rx_byte, i_frame_end);
            end
        end
        pending_count = pending_results.size();
    end

endmodule

>>> dv/modbus_response_checker_top_tb.sv
// ----------------------------------------------------------------------------
// Modbus response checker testbench
// Sends directed and random response frames, byte by byte, with random gaps
// on both channels and one long result stall, and reports the verdict given
// by the monitor's comparison of every result.
// ----------------------------------------------------------------------------
module modbus_response_checker_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import mrc_pkg::*;
    import mrc_tb_pkg::*;

    localparam int RANDOM_BYTES = 800;

    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        i_in_valid  = 1'b0;
    logic [7:0]  i_rx_byte   = 8'h00;
    logic        i_frame_end = 1'b0;
    logic        i_out_ready = 1'b0;
    logic        o_in_ready;
    logic        o_out_valid;
    logic [2:0]  o_status;
    logic [7:0]  o_func_code;
    logic [7:0]  o_exc_code;
    logic [15:0] o_reg_value;

    int error_count;
    int pending;

    logic [7:0] frame_q[$];
    int         bytes_sent = 0;
    bit         random_phase = 1'b0;

    modbus_response_checker_top dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_rx_byte   (i_rx_byte),
        .i_frame_end (i_frame_end),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_status    (o_status),
        .o_func_code (o_func_code),
        .o_exc_code  (o_exc_code),
        .o_reg_value (o_reg_value)
    );

    modbus_response_checker_monitor monitor (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .i_in_ready    (o_in_ready),
        .i_rx_byte     (i_rx_byte),
        .i_frame_end   (i_frame_end),
        .i_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .i_status      (o_status),
        .i_func_code   (o_func_code),
        .i_exc_code    (o_exc_code),
        .i_reg_value   (o_reg_value),
        .o_error_count (error_count),
        .o_pending     (pending)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Mostly no gap or a short one, now and then a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) begin
            return 0;
        end else if (r < 85) begin
            return $urandom_range(1, 3);
        end else if (r < 97) begin
            return $urandom_range(4, 12);
        end
        return $urandom_range(20, 60);
    endfunction

    task automatic make_raw(input int len);
        frame_q.delete();
        repeat (len) frame_q.push_back(8'($urandom_range(0, 255)));
    endtask

    // Header and payload of a frame whose total length, CRC included, is len.
    task automatic make_body(input logic [7:0] fc, input logic [7:0] second,
                             input int len);
        frame_q.delete();
        if (len > 2) frame_q.push_back(8'($urandom_range(0, 255)));
        if (len > 3) frame_q.push_back(fc);
        if (len > 4) frame_q.push_back(second);
        while (frame_q.size() < len - 2) begin
            frame_q.push_back(8'($urandom_range(0, 255)));
        end
    endtask

    // Appends the CRC low byte first; a single flipped bit always spoils it.
    task automatic seal_frame(input bit good);
        logic [15:0] crc;
        int          pos;
        crc = CRC_INIT;
        foreach (frame_q[i]) crc = crc16_update(crc, frame_q[i]);
        frame_q.push_back(crc[7:0]);
        frame_q.push_back(crc[15:8]);
        if (!good) begin
            pos          = $urandom_range(0, frame_q.size() - 1);
            frame_q[pos] = frame_q[pos] ^ (8'h01 << $urandom_range(0, 7));
        end
    endtask

    task automatic push_byte(input logic [7:0] data, input logic last);
        i_in_valid  <= 1'b1;
        i_rx_byte   <= data;
        i_frame_end <= last;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
    endtask

    task automatic send_frame();
        int gap;
        bit steady;
        steady = ($urandom_range(0, 3) == 0);
        for (int i = 0; i < frame_q.size(); i++) begin
            gap = steady ? 0 : pick_gap();
            if (gap > 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            push_byte(frame_q[i], i == frame_q.size() - 1);
            bytes_sent++;
        end
    endtask

    task automatic send_body(input logic [7:0] fc, input logic [7:0] second,
                             input int len, input bit good);
        make_body(fc, second, len);
        seal_frame(good);
        send_frame();
    endtask

    task automatic send_random_frame();
        int         kind;
        int         len;
        logic [7:0] fc;
        logic [7:0] second;
        kind   = $urandom_range(0, 99);
        second = 8'($urandom_range(0, 255));
        if (kind < 30) begin
            len = ($urandom_range(0, 4) == 0) ? $urandom_range(4, 12) : 7;
            if ($urandom_range(0, 9) != 0) second = READ_COUNT;
            send_body(FC_READ, second, len, 1'b1);
        end else if (kind < 55) begin
            len = ($urandom_range(0, 4) == 0) ? $urandom_range(4, 12) : 8;
            send_body(FC_WRITE, second, len, 1'b1);
        end else if (kind < 70) begin
            fc  = $urandom_range(0, 1) ? FC_READ_EXC : FC_WRITE_EXC;
            len = ($urandom_range(0, 3) == 0) ? $urandom_range(4, 8) : 5;
            send_body(fc, second, len, 1'b1);
        end else if (kind < 78) begin
            send_body(8'($urandom_range(0, 255)), second, $urandom_range(4, 10), 1'b1);
        end else if (kind < 90) begin
            case ($urandom_range(0, 4))
                0: fc = FC_READ;
                1: fc = FC_WRITE;
                2: fc = FC_READ_EXC;
                3: fc = FC_WRITE_EXC;
                default: fc = 8'($urandom_range(0, 255));
            endcase
            if (fc == FC_READ) second = READ_COUNT;
            send_body(fc, second, $urandom_range(4, 10), 1'b0);
        end else if (kind < 98) begin
            make_raw($urandom_range(1, 10));
            send_frame();
        end else begin
            // Lengths around the largest legal frame.
            fc = $urandom_range(0, 1) ? FC_READ : 8'($urandom_range(0, 255));
            send_body(fc, READ_COUNT, $urandom_range(250, 262), 1'b1);
        end
    endtask

    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Frames too short to hold an address, a function code and a CRC.
        make_raw(1);
        send_frame();
        make_raw(3);
        send_frame();

        // Read responses at both extremes of the register value.
        make_body(FC_READ, READ_COUNT, 7);
        frame_q[3] = 8'h00;
        frame_q[4] = 8'h00;
        seal_frame(1'b1);
        send_frame();
        make_body(FC_READ, READ_COUNT, 7);
        frame_q[3] = 8'hFF;
        frame_q[4] = 8'hFF;
        seal_frame(1'b1);
        send_frame();
        send_body(FC_READ, 8'h04, 9, 1'b1);
        send_body(FC_READ, READ_COUNT, 6, 1'b1);

        // Write echoes, a full one at each extreme and a truncated one.
        make_body(FC_WRITE, 8'h00, 8);
        frame_q[4] = 8'hFF;
        frame_q[5] = 8'hFF;
        seal_frame(1'b1);
        send_frame();
        make_body(FC_WRITE, 8'hFF, 8);
        frame_q[4] = 8'h00;
        frame_q[5] = 8'h00;
        seal_frame(1'b1);
        send_frame();
        send_body(FC_WRITE, 8'h12, 7, 1'b1);

        // Exceptions for both functions, plus one cut short.
        send_body(FC_READ_EXC, 8'h02, 5, 1'b1);
        send_body(FC_WRITE_EXC, 8'hFF, 5, 1'b1);
        send_body(FC_READ_EXC, 8'h00, 4, 1'b1);

        // Unknown functions and a corrupted read.
        send_body(8'h00, 8'h02, 6, 1'b1);
        send_body(8'hFF, 8'h02, 8, 1'b1);
        send_body(FC_READ, READ_COUNT, 7, 1'b0);

        // The largest legal frame, one byte too many, and a count that
        // saturates well past the limit.
        send_body(FC_READ, READ_COUNT, MAX_FRAME, 1'b1);
        send_body(FC_READ, READ_COUNT, MAX_FRAME + 1, 1'b1);
        make_raw(300);
        send_frame();

        random_phase = 1'b1;
        bytes_sent   = 0;
        while (bytes_sent < RANDOM_BYTES) send_random_frame();

        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);

        if (error_count == 0) begin
            $display("modbus_response_checker_top_tb passed");
        end else begin
            $display("modbus_response_checker_top_tb failed");
        end
        $finish;
    end

    // Result side: random stalls, and once a long hold-off so that the block
    // fills up and stops taking bytes while the sender keeps offering them.
    initial begin
        int  high_len;
        int  gap;
        bit  held;
        held = 1'b0;
        wait (i_rst_n);
        @(posedge i_clk);
        forever begin
            if (random_phase && !held) begin
                held = 1'b1;
                i_out_ready <= 1'b0;
                repeat (600) @(posedge i_clk);
            end else begin
                high_len = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 120)
                                                       : $urandom_range(1, 20);
                i_out_ready <= 1'b1;
                repeat (high_len) @(posedge i_clk);
                gap = pick_gap();
                if (gap > 0) begin
                    i_out_ready <= 1'b0;
                    repeat (gap) @(posedge i_clk);
                end
            end
        end
    end

    initial begin
        #10ms;
        $display("modbus_response_checker_top_tb failed");
        $finish;
    end

endmodule

>>> files.f
+incdir+hdl
hdl/mrc_pkg.sv
hdl/mrc_classify.sv
hdl/modbus_response_checker_top.sv
hdl/mrc_assert_chk.sv
dv/modbus_response_checker_monitor.sv
dv/modbus_response_checker_top_tb.sv
